// File: rtl/wsdf_pkg.sv
// Shared types, codes and constants of the WebSocket frame deframer.
package wsdf_pkg;

  // Default widths and sizes handed to the top level parameters.
  localparam int unsigned LengthBitsDefault = 64;
  localparam int unsigned QueueDepthDefault = 4;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;
  localparam logic [3:0] OP_ERR_LO = 4'hB;

  // Seven-bit length codes.
  localparam logic [6:0] LEN7_DIRECT_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16      = 7'd126;

  // Header byte counts.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Type of the open fragmented message.
  localparam logic [1:0] MSG_NONE   = 2'd0;
  localparam logic [1:0] MSG_TEXT   = 2'd1;
  localparam logic [1:0] MSG_BINARY = 2'd2;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXT    = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CLOSED = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    EV_PAYLOAD    = 3'd0,
    EV_PING       = 3'd1,
    EV_PONG       = 3'd2,
    EV_CLOSE      = 3'd3,
    EV_OPCODE_ERR = 3'd4
  } event_kind_e;

  // One classified request from the parser to the output stage.
  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        is_text;
    logic        fin;
    logic        last;
  } cmd_t;

endpackage

// File: rtl/wsdf_parser.sv
// Front end: header parser and payload classifier, one byte per cycle while take_i is high.
module wsdf_parser #(
  parameter int unsigned LengthBits = wsdf_pkg::LengthBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       rx_byte_i,
  output logic             cmd_valid_o,
  output wsdf_pkg::cmd_t   cmd_o
);

  wsdf_pkg::phase_e phase_q, phase_d;
  logic [3:0]            opcode_q, opcode_d;
  logic                  fin_q, fin_d;
  logic                  mask_q, mask_d;
  logic [3:0]            hcnt_q, hcnt_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic [1:0]            kidx_q, kidx_d;
  logic [31:0]           key_q, key_d;
  logic [1:0]            open_q, open_d;

  logic                  is_data;
  logic                  short_len;
  logic [LengthBits-1:0] len_ext;
  logic [LengthBits-1:0] hdr_len;
  logic                  hdr_done;
  logic                  hdr_zero;
  logic                  data_last;
  logic                  frame_done;
  logic [7:0]            key_byte;
  logic                  emit;

  // Shared decode of the current byte against the parser state.
  always_comb begin
    is_data   = (opcode_q <= wsdf_pkg::OP_BINARY);
    short_len = (rx_byte_i[6:0] <= wsdf_pkg::LEN7_DIRECT_MAX);
    if (len_q[LengthBits-1 -: 8] != 8'd0) begin
      len_ext = {LengthBits{1'b1}};
    end else begin
      len_ext = {len_q[LengthBits-9:0], rx_byte_i};
    end
    case (phase_q)
      wsdf_pkg::PH_HDR1: hdr_len = {{(LengthBits-7){1'b0}}, rx_byte_i[6:0]};
      wsdf_pkg::PH_EXT:  hdr_len = len_ext;
      default:           hdr_len = len_q;
    endcase
    hdr_done = ((phase_q == wsdf_pkg::PH_HDR1) && (opcode_q != wsdf_pkg::OP_CLOSE) &&
                short_len && !rx_byte_i[7]) ||
               ((phase_q == wsdf_pkg::PH_EXT) && (hcnt_q == 4'd1) && !mask_q) ||
               ((phase_q == wsdf_pkg::PH_KEY) && (hcnt_q == 4'd1));
    hdr_zero   = (hdr_len == '0);
    data_last  = (phase_q == wsdf_pkg::PH_DATA) && (rem_q == LengthBits'(1));
    frame_done = (hdr_done && hdr_zero) || data_last;
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    fin_d    = fin_q;
    mask_d   = mask_q;
    hcnt_d   = hcnt_q;
    len_d    = len_q;
    rem_d    = rem_q;
    kidx_d   = kidx_q;
    key_d    = key_q;
    open_d   = open_q;
    if (take_i) begin
      case (phase_q)
        wsdf_pkg::PH_HDR0: begin
          fin_d    = rx_byte_i[7];
          opcode_d = rx_byte_i[3:0];
          phase_d  = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          mask_d = rx_byte_i[7];
          if (opcode_q == wsdf_pkg::OP_CLOSE) begin
            phase_d = wsdf_pkg::PH_CLOSED;
          end else if (!short_len) begin
            len_d   = '0;
            hcnt_d  = (rx_byte_i[6:0] == wsdf_pkg::LEN7_EXT16) ?
                      wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
            phase_d = wsdf_pkg::PH_EXT;
          end else begin
            len_d = hdr_len;
            if (rx_byte_i[7]) begin
              hcnt_d  = wsdf_pkg::KEY_BYTES;
              phase_d = wsdf_pkg::PH_KEY;
            end
          end
        end
        wsdf_pkg::PH_EXT: begin
          len_d  = len_ext;
          hcnt_d = hcnt_q - 4'd1;
          if ((hcnt_q == 4'd1) && mask_q) begin
            hcnt_d  = wsdf_pkg::KEY_BYTES;
            phase_d = wsdf_pkg::PH_KEY;
          end
        end
        wsdf_pkg::PH_KEY: begin
          key_d  = {key_q[23:0], rx_byte_i};
          hcnt_d = hcnt_q - 4'd1;
        end
        wsdf_pkg::PH_DATA: begin
          kidx_d = kidx_q + 2'd1;
          rem_d  = rem_q - LengthBits'(1);
        end
        default: begin
        end
      endcase
      if (hdr_done) begin
        if ((opcode_q == wsdf_pkg::OP_TEXT) || (opcode_q == wsdf_pkg::OP_BINARY)) begin
          open_d = opcode_q[1:0];
        end
        if (!hdr_zero) begin
          rem_d   = hdr_len;
          kidx_d  = 2'd0;
          phase_d = wsdf_pkg::PH_DATA;
        end
      end
      if (frame_done) begin
        phase_d = wsdf_pkg::PH_HDR0;
        if (is_data && fin_q) begin
          open_d = wsdf_pkg::MSG_NONE;
        end
      end
    end
  end

  // Outputs: at most one request per byte.
  always_comb begin
    emit          = 1'b0;
    cmd_o.kind    = wsdf_pkg::EV_PAYLOAD;
    cmd_o.data    = 8'd0;
    cmd_o.key     = 8'd0;
    cmd_o.is_text = 1'b0;
    cmd_o.fin     = 1'b0;
    cmd_o.last    = 1'b0;
    if ((phase_q == wsdf_pkg::PH_DATA) && is_data &&
        ((open_q == wsdf_pkg::MSG_TEXT) || (open_q == wsdf_pkg::MSG_BINARY))) begin
      emit          = 1'b1;
      cmd_o.data    = rx_byte_i;
      cmd_o.key     = mask_q ? key_byte : 8'd0;
      cmd_o.is_text = (open_q == wsdf_pkg::MSG_TEXT);
      cmd_o.fin     = fin_q;
      cmd_o.last    = data_last;
    end else if ((phase_q == wsdf_pkg::PH_HDR1) && (opcode_q == wsdf_pkg::OP_CLOSE)) begin
      emit       = 1'b1;
      cmd_o.kind = wsdf_pkg::EV_CLOSE;
    end else if (frame_done && !is_data) begin
      if (opcode_q == wsdf_pkg::OP_PING) begin
        emit       = 1'b1;
        cmd_o.kind = wsdf_pkg::EV_PING;
      end else if (opcode_q == wsdf_pkg::OP_PONG) begin
        emit       = 1'b1;
        cmd_o.kind = wsdf_pkg::EV_PONG;
      end else if (opcode_q >= wsdf_pkg::OP_ERR_LO) begin
        emit       = 1'b1;
        cmd_o.kind = wsdf_pkg::EV_OPCODE_ERR;
      end
    end
  end

  assign cmd_valid_o = take_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsdf_pkg::PH_HDR0;
      opcode_q <= wsdf_pkg::OP_CONT;
      fin_q    <= 1'b0;
      mask_q   <= 1'b0;
      hcnt_q   <= 4'd0;
      len_q    <= '0;
      rem_q    <= '0;
      kidx_q   <= 2'd0;
      key_q    <= 32'd0;
      open_q   <= wsdf_pkg::MSG_NONE;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      mask_q   <= mask_d;
      hcnt_q   <= hcnt_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      kidx_q   <= kidx_d;
      key_q    <= key_d;
      open_q   <= open_d;
    end
  end

  // Once a close frame is seen, only reset leaves the closed state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsdf_pkg::PH_CLOSED |=> phase_q == wsdf_pkg::PH_CLOSED)
    else $error("parser left the closed state");

  // The down counter of remaining payload bytes never runs dry inside a payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsdf_pkg::PH_DATA |-> rem_q != '0)
    else $error("payload phase with no bytes remaining");

  // Payload requests only come from payload bytes of an open message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && (cmd_o.kind == wsdf_pkg::EV_PAYLOAD) |->
      (phase_q == wsdf_pkg::PH_DATA) && (open_q != wsdf_pkg::MSG_NONE))
    else $error("payload request outside a data payload");

endmodule

// File: rtl/wsdf_fifo.sv
// Short request queue between the parser and the output stage.
module wsdf_fifo #(
  parameter int unsigned Depth = wsdf_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  wsdf_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           rd_valid_o,
  output wsdf_pkg::cmd_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsdf_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("request written into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_i |-> rd_valid_o)
    else $error("request read from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

// File: rtl/wsdf_unmask.sv
// Back end: unmasks payload bytes and holds the oldest result for the consumer.
module wsdf_unmask (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  wsdf_pkg::cmd_t cmd_i,
  output logic           cmd_rd_o,
  input  logic           pop,
  output logic           empty,
  output logic [2:0]     event_kind_o,
  output logic [7:0]     payload_byte_o,
  output logic           is_text_o,
  output logic           frame_fin_o,
  output logic           last_of_frame_o
);

  logic                  out_valid_q, out_valid_d;
  wsdf_pkg::event_kind_e kind_q;
  logic [7:0]            byte_q;
  logic                  text_q;
  logic                  fin_q;
  logic                  last_q;

  // The result register refills in the same cycle that the consumer takes it.
  assign cmd_rd_o = cmd_valid_i && (!out_valid_q || pop);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_rd_o) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) begin
      kind_q <= cmd_i.kind;
      byte_q <= cmd_i.data ^ cmd_i.key;
      text_q <= cmd_i.is_text;
      fin_q  <= cmd_i.fin;
      last_q <= cmd_i.last;
    end
  end

  assign empty           = !out_valid_q;
  assign event_kind_o    = kind_q;
  assign payload_byte_o  = byte_q;
  assign is_text_o       = text_q;
  assign frame_fin_o     = fin_q;
  assign last_of_frame_o = last_q;

  // A waiting result that is not taken must not be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |-> !cmd_rd_o)
    else $error("result register overwritten before it was taken");

  // Event results other than payload bytes carry zero side fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != wsdf_pkg::EV_PAYLOAD) |->
      (byte_q == 8'd0) && !text_q && !fin_q && !last_q)
    else $error("event result with nonzero payload fields");

endmodule

// File: rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: parser, request queue and output stage.
// An accepted byte's result is written into the request queue, then into the result register on the ports.
// Throughput: one received byte per cycle while the queue is not full; the parser updates its state once per byte.
// Full rises only when the request queue of QueueDepth entries fills under a stalled pop.
// Reset clears the parser to the first header byte and drops all queued results.
// After a close frame every byte is taken and dropped until the next reset.
module websocket_frame_deframer #(
  parameter int unsigned LengthBits = wsdf_pkg::LengthBitsDefault,
  parameter int unsigned QueueDepth = wsdf_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       is_text_o,
  output logic       frame_fin_o,
  output logic       last_of_frame_o
);

  logic           take;
  logic           pcmd_valid;
  wsdf_pkg::cmd_t pcmd;
  logic           qcmd_valid;
  wsdf_pkg::cmd_t qcmd;
  logic           qcmd_rd;

  assign take = push && !full;

  wsdf_parser #(
    .LengthBits(LengthBits)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .rx_byte_i  (rx_byte_i),
    .cmd_valid_o(pcmd_valid),
    .cmd_o      (pcmd)
  );

  wsdf_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (pcmd_valid),
    .wr_data_i (pcmd),
    .full_o    (full),
    .rd_i      (qcmd_rd),
    .rd_valid_o(qcmd_valid),
    .rd_data_o (qcmd)
  );

  wsdf_unmask u_unmask (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (qcmd_valid),
    .cmd_i          (qcmd),
    .cmd_rd_o       (qcmd_rd),
    .pop            (pop),
    .empty          (empty),
    .event_kind_o   (event_kind_o),
    .payload_byte_o (payload_byte_o),
    .is_text_o      (is_text_o),
    .frame_fin_o    (frame_fin_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the WebSocket frame deframer.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LEN_BITS    = wsdf_pkg::LengthBitsDefault;
  localparam logic [63:0] LEN_MAX     = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);
  localparam logic [6:0]  LEN7_EXT64  = 7'd127;
  localparam int          LEN_DIRECT  = 0;
  localparam int          LEN_16      = 1;
  localparam int          LEN_64      = 2;
  localparam int          SETTLE_CYC  = 10;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    wsdf_pkg::event_kind_e kind;
    logic [7:0]            data;
    logic                  is_text;
    logic                  fin;
    logic                  last;
  } ws_event_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] event_kind_o;
  logic [7:0] payload_byte_o;
  logic       is_text_o;
  logic       frame_fin_o;
  logic       last_of_frame_o;

  websocket_frame_deframer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .pop            (pop),
    .empty          (empty),
    .event_kind_o   (event_kind_o),
    .payload_byte_o (payload_byte_o),
    .is_text_o      (is_text_o),
    .frame_fin_o    (frame_fin_o),
    .last_of_frame_o(last_of_frame_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ws_event_t   pending_events[$];
  int          err_cnt     = 0;
  int unsigned sent_bytes  = 0;
  int unsigned cycle_count = 0;
  int          send_idle   = 0;
  int          recv_stall  = 0;
  int          hold_token  = 0;

  // Parser state mirrored by the predictor.
  wsdf_pkg::phase_e ph;
  logic [3:0]       cur_op;
  logic             cur_fin;
  logic             cur_mask;
  logic [3:0]       hdr_left;
  logic [63:0]      plen;
  logic [63:0]      pidx;
  logic [31:0]      mkey;
  logic [1:0]       open_type;

  function automatic void parser_clear();
    ph        = wsdf_pkg::PH_HDR0;
    cur_op    = wsdf_pkg::OP_CONT;
    cur_fin   = 1'b0;
    cur_mask  = 1'b0;
    hdr_left  = '0;
    plen      = '0;
    pidx      = '0;
    mkey      = '0;
    open_type = wsdf_pkg::MSG_NONE;
  endfunction

  function automatic void emit(wsdf_pkg::event_kind_e k, logic [7:0] d, logic t, logic f,
                               logic l);
    ws_event_t e;
    e = '{k, d, t, f, l};
    pending_events.push_back(e);
  endfunction

  function automatic void frame_done();
    ph = wsdf_pkg::PH_HDR0;
    if (cur_op <= wsdf_pkg::OP_BINARY) begin
      if (cur_fin) open_type = wsdf_pkg::MSG_NONE;
    end else if (cur_op == wsdf_pkg::OP_PING) begin
      emit(wsdf_pkg::EV_PING, 8'h00, 1'b0, 1'b0, 1'b0);
    end else if (cur_op == wsdf_pkg::OP_PONG) begin
      emit(wsdf_pkg::EV_PONG, 8'h00, 1'b0, 1'b0, 1'b0);
    end else if (cur_op >= wsdf_pkg::OP_ERR_LO) begin
      emit(wsdf_pkg::EV_OPCODE_ERR, 8'h00, 1'b0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void header_complete();
    if (cur_op == wsdf_pkg::OP_TEXT || cur_op == wsdf_pkg::OP_BINARY) open_type = cur_op[1:0];
    if (plen == 0) begin
      frame_done();
    end else begin
      pidx = '0;
      ph   = wsdf_pkg::PH_DATA;
    end
  endfunction

  function automatic void length_complete();
    if (cur_mask) begin
      hdr_left = wsdf_pkg::KEY_BYTES;
      ph       = wsdf_pkg::PH_KEY;
    end else begin
      header_complete();
    end
  endfunction

  // Advances the mirrored parser by one received byte and queues any event that it causes.
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] kb;
    logic [7:0] val;
    logic       last;
    case (ph)
      wsdf_pkg::PH_HDR1: begin
        cur_mask = b[7];
        if (cur_op == wsdf_pkg::OP_CLOSE) begin
          ph = wsdf_pkg::PH_CLOSED;
          emit(wsdf_pkg::EV_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
        end else if (b[6:0] <= wsdf_pkg::LEN7_DIRECT_MAX) begin
          plen = {57'd0, b[6:0]};
          length_complete();
        end else begin
          plen     = '0;
          hdr_left = (b[6:0] == wsdf_pkg::LEN7_EXT16) ?
                     wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
          ph       = wsdf_pkg::PH_EXT;
        end
      end
      wsdf_pkg::PH_EXT: begin
        if ((plen >> (LEN_BITS - 8)) != 0) plen = LEN_MAX;
        else plen = ((plen << 8) | {56'd0, b}) & LEN_MAX;
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) length_complete();
      end
      wsdf_pkg::PH_KEY: begin
        mkey     = {mkey[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) header_complete();
      end
      wsdf_pkg::PH_DATA: begin
        kb   = cur_mask ? mkey[8 * (3 - pidx[1:0]) +: 8] : 8'h00;
        val  = b ^ kb;
        pidx = pidx + 64'd1;
        last = (pidx >= plen);
        if (cur_op <= wsdf_pkg::OP_BINARY &&
            (open_type == wsdf_pkg::MSG_TEXT || open_type == wsdf_pkg::MSG_BINARY)) begin
          emit(wsdf_pkg::EV_PAYLOAD, val, open_type == wsdf_pkg::MSG_TEXT, cur_fin, last);
        end
        if (last) frame_done();
      end
      wsdf_pkg::PH_CLOSED: begin
      end
      default: begin
        cur_fin = b[7];
        cur_op  = b[3:0];
        ph      = wsdf_pkg::PH_HDR1;
      end
    endcase
  endfunction

  // Result side: pops with random stalls and compares against the oldest expectation.
  int hold_seen = 0;
  int hold_left = 0;

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    ws_event_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_events.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                 $time, event_kind_o, payload_byte_o);
      end else begin
        e = pending_events.pop_front();
        check_field("event_kind", 8'(e.kind), 8'(event_kind_o));
        check_field("payload_byte", e.data, payload_byte_o);
        check_field("is_text", 8'(e.is_text), 8'(is_text_o));
        check_field("frame_fin", 8'(e.fin), 8'(frame_fin_o));
        check_field("last_of_frame", 8'(e.last), 8'(last_of_frame_o));
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one byte, with a random gap before it, and holds it until accepted.
  task automatic send_byte(input logic [7:0] b);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    deframe_byte(b);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input logic [31:0] key,
                            input logic [63:0] len, input int form);
    logic [6:0] code;
    case (form)
      LEN_16:  code = wsdf_pkg::LEN7_EXT16;
      LEN_64:  code = LEN7_EXT64;
      default: code = len[6:0];
    endcase
    send_byte({fin, rsv, op});
    send_byte({masked, code});
    if (form == LEN_16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == LEN_64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (longint unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  // A frame of the given kind with random length form, mask, key and reserved bits.
  task automatic send_rand_frame(input logic fin, input logic [3:0] op);
    int s;
    int form;
    logic [63:0] len;
    s = $urandom_range(99);
    if (s < 70) begin
      form = LEN_DIRECT;
      len  = 64'($urandom_range(0, 6));
    end else if (s < 78) begin
      form = LEN_DIRECT;
      len  = 64'($urandom_range(7, 125));
    end else if (s < 90) begin
      form = LEN_16;
      len  = ($urandom_range(9) == 0) ? 64'($urandom_range(126, 140)) :
                                        64'($urandom_range(0, 20));
    end else begin
      form = LEN_64;
      len  = 64'($urandom_range(0, 12));
    end
    send_frame(fin, 3'($urandom), op, 1'($urandom), $urandom, len, form);
  endtask

  // A message of one to four frames, sometimes with a control frame in the middle.
  task automatic send_rand_message();
    int n;
    n = $urandom_range(0, 3);
    send_rand_frame(n == 0,
                    ($urandom_range(1) == 1) ? wsdf_pkg::OP_TEXT : wsdf_pkg::OP_BINARY);
    for (int i = 1; i <= n; i++) begin
      if ($urandom_range(5) == 0)
        send_rand_frame(1'($urandom),
                        ($urandom_range(1) == 1) ? wsdf_pkg::OP_PING : wsdf_pkg::OP_PONG);
      send_rand_frame(i == n, wsdf_pkg::OP_CONT);
    end
  endtask

  // Noise: any opcode except close, with random FIN.
  task automatic send_noise_frame();
    logic [3:0] op;
    op = 4'($urandom_range(15));
    if (op == wsdf_pkg::OP_CLOSE) op = wsdf_pkg::OP_CONT;
    send_rand_frame(1'($urandom), op);
  endtask

  task automatic settle_results();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic test_single_frames();
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_TEXT, 1'b0, 32'h0, 64'd3, LEN_DIRECT);
    send_frame(1'b1, 3'b111, wsdf_pkg::OP_BINARY, 1'b1, 32'hA5C3_0FF0, 64'd6, LEN_DIRECT);
    settle_results();
  endtask

  task automatic test_fragmentation();
    send_frame(1'b0, 3'b000, wsdf_pkg::OP_TEXT, 1'b1, 32'h1234_5678, 64'd2, LEN_DIRECT);
    send_frame(1'b0, 3'b000, wsdf_pkg::OP_CONT, 1'b0, 32'h0, 64'd1, LEN_DIRECT);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_CONT, 1'b1, 32'hFFFF_FFFF, 64'd2, LEN_DIRECT);
    // Continuation with no open message is dropped.
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_CONT, 1'b0, 32'h0, 64'd2, LEN_DIRECT);
    // A text start replaces the open binary message.
    send_frame(1'b0, 3'b000, wsdf_pkg::OP_BINARY, 1'b0, 32'h0, 64'd1, LEN_DIRECT);
    send_frame(1'b0, 3'b000, wsdf_pkg::OP_TEXT, 1'b0, 32'h0, 64'd1, LEN_DIRECT);
    // An empty final continuation still closes the message.
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_CONT, 1'b0, 32'h0, 64'd0, LEN_DIRECT);
    send_frame(1'b0, 3'b000, wsdf_pkg::OP_CONT, 1'b0, 32'h0, 64'd1, LEN_DIRECT);
    settle_results();
  endtask

  task automatic test_control_frames();
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_PING, 1'b1, 32'hDEAD_BEEF, 64'd3, LEN_DIRECT);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_PONG, 1'b0, 32'h0, 64'd0, LEN_DIRECT);
    send_frame(1'b1, 3'b000, 4'h3, 1'b0, 32'h0, 64'd2, LEN_DIRECT);
    send_frame(1'b0, 3'b000, 4'h7, 1'b1, 32'h0, 64'd0, LEN_DIRECT);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_ERR_LO, 1'b0, 32'h0, 64'd0, LEN_DIRECT);
    send_frame(1'b1, 3'b000, 4'hF, 1'b1, 32'h0102_0304, 64'd2, LEN_DIRECT);
    // Control frame in the middle of a fragmented message.
    send_frame(1'b0, 3'b000, wsdf_pkg::OP_TEXT, 1'b0, 32'h0, 64'd1, LEN_DIRECT);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_PING, 1'b0, 32'h0, 64'd1, LEN_DIRECT);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_CONT, 1'b0, 32'h0, 64'd1, LEN_DIRECT);
    settle_results();
  endtask

  task automatic test_length_forms();
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_TEXT, 1'b0, 32'h0, 64'd0, LEN_16);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_BINARY, 1'b1, 32'h55AA_33CC, 64'd3, LEN_64);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_BINARY, 1'b0, 32'h0, 64'd125, LEN_DIRECT);
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_PONG, 1'b0, 32'h0, 64'd0, LEN_64);
    settle_results();
  endtask

  // A 16-bit extended length that needs its high byte.
  task automatic test_long_lengths();
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_BINARY, 1'b1, $urandom, 64'd259, LEN_16);
    settle_results();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int unsigned quota);
    int unsigned stop_at;
    send_idle  = idle;
    recv_stall = stall;
    stop_at    = sent_bytes + quota;
    while (sent_bytes < stop_at) begin
      if ($urandom_range(9) < 7) send_rand_message();
      else send_noise_frame();
    end
    settle_results();
  endtask

  // The receiver holds off while the sender keeps offering, so the queue fills.
  task automatic test_backpressure();
    int unsigned stop_at;
    send_idle  = 0;
    recv_stall = 0;
    hold_token++;
    stop_at = sent_bytes + 60;
    while (sent_bytes < stop_at)
      send_frame(1'b1, 3'($urandom), wsdf_pkg::OP_BINARY, 1'($urandom), $urandom,
                 64'($urandom_range(1, 12)), LEN_DIRECT);
    settle_results();
  endtask

  // After the close event every byte is dropped.
  task automatic test_close();
    send_idle  = 0;
    recv_stall = 0;
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_CLOSE, 1'b1, 32'hCAFE_F00D, 64'd2, LEN_DIRECT);
    send_rand_message();
    send_frame(1'b1, 3'b000, wsdf_pkg::OP_PING, 1'b0, 32'h0, 64'd0, LEN_DIRECT);
    settle_results();
  endtask

  initial begin
    parser_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_frames();
    test_fragmentation();
    test_control_frames();
    test_length_forms();
    test_long_lengths();
    test_random_traffic(0, 0, 30);
    test_random_traffic(51, 0, 30);
    test_random_traffic(0, 51, 30);
    test_random_traffic(8, 8, 30);
    test_backpressure();
    test_close();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
